// ===== hdl/text_cell_rle_decoder_top_macros.svh =====
// assertion macros shared by the text cell decoder modules
// expects clk and rst_n to be visible where a macro is used
`ifndef TEXT_CELL_RLE_DECODER_TOP_MACROS_SVH
`define TEXT_CELL_RLE_DECODER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define TCRLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcrld_pkg.sv =====
// shared types and constants for the text cell run-length decoder
// no dependencies
package tcrld_pkg;

    localparam int CELL_WIDTH = 8;
    localparam int COORD_BITS = 12;

    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT_MODE  = 2'd0;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd3;

    localparam logic [7:0]  GLYPH_HEIGHT_RST = 8'd8;
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd400;

    // record types from the header byte
    localparam logic [1:0] KIND_LITERAL  = 2'd0;
    localparam logic [1:0] KIND_CHAR_RUN = 2'd1;
    localparam logic [1:0] KIND_ATTR_RUN = 2'd2;
    localparam logic [1:0] KIND_CELL_RUN = 2'd3;

    typedef enum logic [4:0] {
        PH_HEAD   = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_SECOND = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_PLAIN  = 5'b10000
    } phase_t;

    // one queued command: draw count copies of a cell, then maybe home the cursor
    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [6:0] count;
        logic       pkt_end;
    } cmd_t;

endpackage

// ===== hdl/tcrld_front.sv =====
// byte parser: turns packet bytes into cell commands
// depends on tcrld_pkg
module tcrld_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      byte_value,
    input  logic            packet_end,
    input  logic            format_mode,
    input  logic            fmt_wr,
    input  logic            cmd_full,
    output logic            cmd_push,
    output tcrld_pkg::cmd_t cmd_data
);
    import tcrld_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [6:0] left_reg, left_next;
    logic [7:0] char_reg, char_next;
    logic [7:0] attr_reg, attr_next;

    logic       accept;
    logic       gen;
    logic [6:0] left_dec;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign left_dec = left_reg - 7'd1;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        char_next  = char_reg;
        attr_next  = attr_reg;
        gen        = 1'b0;
        cmd_data.char_code = char_reg;
        cmd_data.attr      = byte_value;
        cmd_data.count     = 7'd1;
        cmd_data.pkt_end   = packet_end;

        if (accept)
        begin
            if (!format_mode)
            begin
                if (phase_reg == PH_PLAIN)
                begin
                    gen        = 1'b1;
                    phase_next = PH_HEAD;
                end
                else
                begin
                    char_next  = byte_value;
                    phase_next = PH_PLAIN;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (kind_reg == KIND_ATTR_RUN)
                        begin
                            attr_next  = byte_value;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            char_next  = byte_value;
                            phase_next = (kind_reg == KIND_CHAR_RUN) ? PH_DATA : PH_SECOND;
                        end
                    end
                    PH_SECOND:
                    begin
                        if (kind_reg == KIND_CELL_RUN)
                        begin
                            // whole run goes out on the attribute byte
                            attr_next      = byte_value;
                            gen            = 1'b1;
                            cmd_data.count = left_reg;
                            left_next      = 7'd0;
                            phase_next     = PH_HEAD;
                        end
                        else if (kind_reg == KIND_LITERAL)
                        begin
                            gen        = 1'b1;
                            left_next  = left_dec;
                            phase_next = (left_dec == 7'd0) ? PH_HEAD : PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_DATA:
                    begin
                        if (kind_reg == KIND_CHAR_RUN)
                        begin
                            attr_next  = byte_value;
                            gen        = 1'b1;
                            left_next  = left_dec;
                            phase_next = (left_dec == 7'd0) ? PH_HEAD : PH_DATA;
                        end
                        else if (kind_reg == KIND_ATTR_RUN)
                        begin
                            char_next          = byte_value;
                            gen                = 1'b1;
                            cmd_data.char_code = byte_value;
                            cmd_data.attr      = attr_reg;
                            left_next          = left_dec;
                            phase_next         = (left_dec == 7'd0) ? PH_HEAD : PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_HEAD;
                        end
                    end
                    default:
                    begin
                        // header: type in the top two bits, count minus one below
                        kind_next  = byte_value[7:6];
                        left_next  = {1'b0, byte_value[5:0]} + 7'd1;
                        phase_next = PH_FIRST;
                    end
                endcase
            end

            if (packet_end)
            begin
                phase_next = PH_HEAD;
                left_next  = 7'd0;
            end
        end

        if (!gen)
        begin
            cmd_data.count = 7'd0;
        end

        if (fmt_wr)
        begin
            phase_next = PH_HEAD;
        end
    end

    assign cmd_push = accept && (gen || packet_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            kind_reg  <= KIND_LITERAL;
            left_reg  <= 7'd0;
            char_reg  <= 8'd0;
            attr_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            char_reg  <= char_next;
            attr_reg  <= attr_next;
        end
    end

endmodule

// ===== hdl/tcrld_cmd_fifo.sv =====
// short command queue between the byte parser and the cell engine
// depends on tcrld_pkg and text_cell_rle_decoder_top_macros.svh
`include "text_cell_rle_decoder_top_macros.svh"

module tcrld_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tcrld_pkg::cmd_t wr_data,
    output logic            full,
    input  logic            pop,
    output tcrld_pkg::cmd_t rd_data,
    output logic            empty
);
    import tcrld_pkg::*;

    cmd_t                    mem [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_BITS:0]   count_reg, count_next;

    assign full    = (count_reg == (CMD_PTR_BITS+1)'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TCRLD_ASSERT_SAME(a_no_overflow, push, !full, "command pushed into a full queue")
    `TCRLD_ASSERT_SAME(a_no_underflow, pop, !empty, "command popped from an empty queue")
    `TCRLD_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

// ===== hdl/tcrld_back.sv =====
// cell engine: walks the cursor and emits one cell per cycle into a free or popped output register
// depends on tcrld_pkg and text_cell_rle_decoder_top_macros.svh
`include "text_cell_rle_decoder_top_macros.svh"

module tcrld_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcrld_pkg::cmd_t                     cmd,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic [7:0]                          glyph_height,
    input  logic [tcrld_pkg::COORD_BITS-1:0]    frame_width,
    input  logic [tcrld_pkg::COORD_BITS-1:0]    frame_height,
    input  logic                                pop,
    output logic                                empty,
    output logic [tcrld_pkg::COORD_BITS-1:0]    cell_column,
    output logic [tcrld_pkg::COORD_BITS-1:0]    cell_row,
    output logic [7:0]                          char_code,
    output logic [3:0]                          fore_colour,
    output logic [3:0]                          back_colour,
    output logic                                run_final
);
    import tcrld_pkg::*;

    localparam logic [COORD_BITS-1:0] STEP = COORD_BITS'(CELL_WIDTH);

    logic [COORD_BITS-1:0] cursor_col_reg, cursor_col_next;
    logic [COORD_BITS-1:0] cursor_row_reg, cursor_row_next;
    logic [6:0]            sent_reg, sent_next;
    logic                  out_valid_reg, out_valid_next;

    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [7:0]            char_reg;
    logic [7:0]            attr_reg;
    logic                  final_reg;

    logic                  active;
    logic                  cur_drop;
    logic                  next_drop;
    logic                  none_left;
    logic                  last;
    logic                  can_emit;
    logic                  emit;
    logic                  retire;
    logic                  wrap;
    logic [COORD_BITS-1:0] col_adv;
    logic [COORD_BITS-1:0] col_step;
    logic [COORD_BITS-1:0] row_step;
    logic [COORD_BITS-1:0] gh_ext;

    assign gh_ext    = COORD_BITS'(glyph_height);
    assign active    = !cmd_empty;
    // a cell whose bottom falls below the frame is dropped and the cursor stays
    assign cur_drop  = ({1'b0, cursor_row_reg} + {1'b0, gh_ext}) > {1'b0, frame_height};
    assign none_left = (sent_reg == cmd.count);
    assign last      = ((sent_reg + 7'd1) == cmd.count);
    assign can_emit  = !out_valid_reg || pop;

    // cursor after one cell, with wrap to the next glyph row
    assign col_adv   = cursor_col_reg + STEP;
    assign wrap      = ({1'b0, col_adv} + {1'b0, STEP}) > {1'b0, frame_width};
    assign col_step  = wrap ? '0 : col_adv;
    assign row_step  = wrap ? cursor_row_reg + gh_ext : cursor_row_reg;
    assign next_drop = ({1'b0, row_step} + {1'b0, gh_ext}) > {1'b0, frame_height};

    assign emit    = active && !none_left && !cur_drop && can_emit;
    assign retire  = active && (none_left || cur_drop || (emit && (last || next_drop)));
    assign cmd_pop = retire;

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (emit)
        begin
            cursor_col_next = col_step;
            cursor_row_next = row_step;
        end
        if (retire && cmd.pkt_end)
        begin
            cursor_col_next = '0;
            cursor_row_next = '0;
        end

        if (retire)
        begin
            sent_next = 7'd0;
        end
        else if (emit)
        begin
            sent_next = sent_reg + 7'd1;
        end
        else
        begin
            sent_next = sent_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            sent_reg       <= 7'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            sent_reg       <= sent_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            col_reg   <= cursor_col_reg;
            row_reg   <= cursor_row_reg;
            char_reg  <= cmd.char_code;
            attr_reg  <= cmd.attr;
            // the last cell of the run, or later cells of the run would all be dropped
            final_reg <= last || next_drop;
        end
    end

    assign empty       = !out_valid_reg;
    assign cell_column = col_reg;
    assign cell_row    = row_reg;
    assign char_code   = char_reg;
    assign fore_colour = attr_reg[3:0];
    assign back_colour = attr_reg[7:4];
    assign run_final   = final_reg;

    `TCRLD_ASSERT_SAME(a_col_aligned, 1'b1, (cursor_col_reg & (STEP - 1'b1)) == '0, "cursor column off the cell grid")
    `TCRLD_ASSERT_NEXT(a_end_home, retire && cmd.pkt_end, cursor_col_reg == '0 && cursor_row_reg == '0, "cursor not homed after packet end")
    `TCRLD_ASSERT_SAME(a_sent_bound, sent_reg != 7'd0, !cmd_empty && sent_reg < cmd.count, "cell count ran past the command")

endmodule

// ===== hdl/text_cell_rle_decoder_top.sv =====
// Text cell decoder: packet bytes in, placed character cells out. Plain mode
// takes character/attribute pairs; XBIN mode takes run-length records. The
// byte parser accepts one byte per cycle while the queue is not full and
// queues cell commands in a four-entry queue; the cell engine emits one cell
// per cycle while its output register is free or popped, so a run holds the
// engine while input keeps flowing until the queue fills. A run that falls
// below the frame bottom is retired without emitting those cells. The user
// must write configuration only while the block is idle; the block does not
// enforce this. Depends on tcrld_pkg, tcrld_front, tcrld_cmd_fifo, tcrld_back.
module text_cell_rle_decoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       byte_value,
    input  logic                             packet_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [tcrld_pkg::COORD_BITS-1:0] cell_column,
    output logic [tcrld_pkg::COORD_BITS-1:0] cell_row,
    output logic [7:0]                       char_code,
    output logic [3:0]                       fore_colour,
    output logic [3:0]                       back_colour,
    output logic                             run_final,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [11:0]                      cfg_data
);
    import tcrld_pkg::*;

    logic                  format_mode_reg;
    logic [7:0]            glyph_height_reg;
    logic [COORD_BITS-1:0] frame_width_reg;
    logic [COORD_BITS-1:0] frame_height_reg;

    logic fmt_wr;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_head;

    assign fmt_wr = cfg_we && (cfg_index == CFG_FORMAT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg  <= 1'b0;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
            frame_width_reg  <= COORD_BITS'(FRAME_WIDTH_RST);
            frame_height_reg <= COORD_BITS'(FRAME_HEIGHT_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORMAT_MODE:  format_mode_reg  <= cfg_data[0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[7:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= COORD_BITS'(cfg_data);
                CFG_FRAME_HEIGHT: frame_height_reg <= COORD_BITS'(cfg_data);
                default:          format_mode_reg  <= format_mode_reg;
            endcase
        end
    end

    tcrld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_value  (byte_value),
        .packet_end  (packet_end),
        .format_mode (format_mode_reg),
        .fmt_wr      (fmt_wr),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in)
    );

    tcrld_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    tcrld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_head),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .glyph_height (glyph_height_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pop          (pop),
        .empty        (empty),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .char_code    (char_code),
        .fore_colour  (fore_colour),
        .back_colour  (back_colour),
        .run_final    (run_final)
    );

endmodule

// ===== tb/text_cell_rle_decoder_top_tb.sv =====
// self-checking testbench for text_cell_rle_decoder_top: plain and run-length packets
// are pushed in, placed cells are predicted in-line and compared as they are popped
// depends on tcrld_pkg and text_cell_rle_decoder_top
module text_cell_rle_decoder_top_tb;
    import tcrld_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 3000;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  code;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic        last;
    } cell_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_value = 8'd0;
    logic        packet_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [11:0] cell_column;
    logic [11:0] cell_row;
    logic [7:0]  char_code;
    logic [3:0]  fore_colour;
    logic [3:0]  back_colour;
    logic        run_final;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_FORMAT_MODE;
    logic [11:0] cfg_data = 12'd0;

    text_cell_rle_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_value  (byte_value),
        .packet_end  (packet_end),
        .empty       (empty),
        .pop         (pop),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .char_code   (char_code),
        .fore_colour (fore_colour),
        .back_colour (back_colour),
        .run_final   (run_final),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    byte_item_t bytes_to_send[$];
    cell_t      cells_due[$];
    byte_item_t next_byte;
    int         send_idle_pct = 0;
    int         pop_stall_pct = 0;
    int         fail_count = 0;
    int         stall_cycles = 0;

    // predictor copy of the registers and parser state
    logic       mode_r = 1'b0;
    logic [7:0] gh_r = GLYPH_HEIGHT_RST;
    logic [11:0] fw_r = FRAME_WIDTH_RST;
    logic [11:0] fh_r = FRAME_HEIGHT_RST;
    logic [11:0] cur_col = 12'd0;
    logic [11:0] cur_row = 12'd0;
    phase_t     parse = PH_HEAD;
    logic [1:0] kind = KIND_LITERAL;
    logic [6:0] remaining = 7'd0;
    logic [7:0] chr_hold = 8'd0;
    logic [7:0] attr_hold = 8'd0;
    int         placed = 0;

    task automatic place_cell(input logic [7:0] ch, input logic [7:0] attr);
        cell_t c;
        // cells below the frame bottom are dropped and the cursor stays
        if (int'(cur_row) + int'(gh_r) <= int'(fh_r))
        begin
            c.column = cur_col;
            c.row    = cur_row;
            c.code   = ch;
            c.fg     = attr[3:0];
            c.bg     = attr[7:4];
            c.last   = 1'b0;
            cells_due.push_back(c);
            placed++;
            cur_col = cur_col + 12'(CELL_WIDTH);
            if (int'(cur_col) + CELL_WIDTH > int'(fw_r))
            begin
                cur_col = 12'd0;
                cur_row = cur_row + 12'(gh_r);
            end
        end
    endtask

    task automatic count_down();
        remaining = remaining - 7'd1;
        if (remaining == 7'd0)
            parse = PH_HEAD;
        else if (kind == KIND_LITERAL)
            parse = PH_FIRST;
        else
            parse = PH_DATA;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        placed = 0;
        if (mode_r == 1'b0)
        begin
            if (parse == PH_PLAIN)
            begin
                place_cell(chr_hold, b);
                parse = PH_HEAD;
            end
            else
            begin
                chr_hold = b;
                parse = PH_PLAIN;
            end
        end
        else
        begin
            case (parse)
                PH_FIRST:
                begin
                    if (kind == KIND_ATTR_RUN)
                    begin
                        attr_hold = b;
                        parse = PH_DATA;
                    end
                    else
                    begin
                        chr_hold = b;
                        if (kind == KIND_CHAR_RUN)
                            parse = PH_DATA;
                        else
                            parse = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    if (kind == KIND_CELL_RUN)
                    begin
                        // whole run goes out on the attribute byte
                        attr_hold = b;
                        for (int i = 0; i < int'(remaining) && i < 64; i++)
                            place_cell(chr_hold, b);
                        remaining = 7'd0;
                        parse = PH_HEAD;
                    end
                    else if (kind == KIND_LITERAL)
                    begin
                        place_cell(chr_hold, b);
                        count_down();
                    end
                    else
                        parse = PH_HEAD;
                end
                PH_DATA:
                begin
                    if (kind == KIND_CHAR_RUN)
                    begin
                        attr_hold = b;
                        place_cell(chr_hold, b);
                        count_down();
                    end
                    else if (kind == KIND_ATTR_RUN)
                    begin
                        chr_hold = b;
                        place_cell(b, attr_hold);
                        count_down();
                    end
                    else
                        parse = PH_HEAD;
                end
                default:
                begin
                    kind = b[7:6];
                    remaining = {1'b0, b[5:0]} + 7'd1;
                    parse = PH_FIRST;
                end
            endcase
        end
        if (placed > 0)
            cells_due[cells_due.size() - 1].last = 1'b1;
        // packet end homes the cursor and drops any partial record
        if (last)
        begin
            cur_col = 12'd0;
            cur_row = 12'd0;
            parse = PH_HEAD;
            remaining = 7'd0;
        end
    endtask

    // driver: one transaction per accepted push
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            byte_value <= 8'd0;
            packet_end <= 1'b0;
        end
        else
        begin
            if (push && !full)
                decode_byte(byte_value, packet_end);
            if (!push || !full)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = bytes_to_send.pop_front();
                    push <= 1'b1;
                    byte_value <= next_byte.value;
                    packet_end <= next_byte.last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_cell();
        cell_t want;
        if (cells_due.size() == 0)
        begin
            $display("%0t: unexpected cell, expected none actual col %0d row %0d code %0d",
                     $time, cell_column, cell_row, char_code);
            fail_count++;
        end
        else
        begin
            want = cells_due.pop_front();
            check_field("cell_column", want.column, cell_column);
            check_field("cell_row", want.row, cell_row);
            check_field("char_code", want.code, char_code);
            check_field("fore_colour", want.fg, fore_colour);
            check_field("back_colour", want.bg, back_colour);
            check_field("run_final", want.last, run_final);
        end
    endtask

    // monitor: check each popped transaction, then pick the next pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                compare_cell();
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic add_byte(input logic [7:0] value, input logic last);
        byte_item_t it;
        it.value = value;
        it.last = last;
        bytes_to_send.push_back(it);
    endtask

    // wait until all bytes are in and every predicted cell has come out
    task automatic settle();
        @(negedge clk);
        while (bytes_to_send.size() != 0 || push || cells_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_FORMAT_MODE:
            begin
                mode_r = value[0];
                parse = PH_HEAD;
            end
            CFG_GLYPH_HEIGHT: gh_r = value[7:0];
            CFG_FRAME_WIDTH:  fw_r = value;
            default:          fh_r = value;
        endcase
    endtask

    task automatic start_phase(input logic mode, input int gh, input int fw, input int fh,
                               input int send_pct, input int stall_pct);
        settle();
        write_reg(CFG_GLYPH_HEIGHT, 12'(gh));
        write_reg(CFG_FRAME_WIDTH, 12'(fw));
        write_reg(CFG_FRAME_HEIGHT, 12'(fh));
        write_reg(CFG_FORMAT_MODE, {11'd0, mode});
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    // mostly well-formed records or pairs with random content, some cut short
    task automatic fill_random(input int target);
        int         queued;
        int         rec_kind;
        int         count;
        int         plen;
        int         cut;
        logic [7:0] head;
        queued = 0;
        while (queued < target)
        begin
            if (mode_r == 1'b0)
            begin
                if ($urandom_range(99) < 6)
                begin
                    add_byte(8'($urandom_range(255)), 1'b1);
                    queued += 1;
                end
                else
                begin
                    add_byte(8'($urandom_range(255)), 1'b0);
                    add_byte(8'($urandom_range(255)), $urandom_range(99) < 12);
                    queued += 2;
                end
            end
            else
            begin
                rec_kind = $urandom_range(3);
                count = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(4, 1);
                head = {2'(rec_kind), 6'(count - 1)};
                if (2'(rec_kind) == KIND_LITERAL)
                    plen = 1 + 2 * count;
                else if (2'(rec_kind) == KIND_CELL_RUN)
                    plen = 3;
                else
                    plen = 2 + count;
                cut = plen;
                if ($urandom_range(99) < 10)
                    cut = $urandom_range(plen - 1, 1);
                for (int j = 0; j < cut; j++)
                    add_byte((j == 0) ? head : 8'($urandom_range(255)),
                             (j == cut - 1) && (cut < plen || $urandom_range(99) < 15));
                queued += cut;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // plain pairs at the byte extremes, then an odd trailing byte
        start_phase(1'b0, 8, 640, 400, 0, 0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h41, 1'b1);

        // one record of each type, a full 64-cell run, and a truncated literal record
        start_phase(1'b1, 8, 640, 400, 0, 0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h1E, 1'b0);
        add_byte(8'h30, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hDB, 1'b0);
        add_byte(8'h4E, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h07, 1'b0);
        add_byte(8'h62, 1'b1);

        // narrow frame wraps every cell and the run runs off the bottom
        start_phase(1'b1, 8, 8, 16, 0, 0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h2A, 1'b0);
        add_byte(8'h71, 1'b0);

        start_phase(1'b1, 8, 640, 400, 0, 0);
        fill_random(21);
        // hold the sender until the block has drained
        settle();
        fill_random(21);

        start_phase(1'b0, 16, 4095, 4095, 65, 0);
        fill_random(42);

        start_phase(1'b1, 255, 8, 4095, 0, 65);
        fill_random(42);

        start_phase(1'b1, 1, 100, 1, 25, 25);
        fill_random(42);

        // zero glyph height keeps every cell on row 0
        start_phase(1'b1, 0, 24, 4095, 25, 25);
        fill_random(42);

        start_phase(1'b1, 64, 1000, 200, 65, 65);
        fill_random(42);

        settle();
        if (fail_count == 0 && cells_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
